@@ rtl/lpht_pkg.sv @@
`default_nettype none
package lpht_pkg;
    localparam int unsigned KEY_W = 64;
    localparam int unsigned PAY_W = 64;
    localparam int unsigned LEN_W = 4;

    typedef enum logic [1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_DUP  = 2'd2,
        ST_FULL = 2'd3
    } status_t;

    localparam logic [31:0] HP1 = 32'h9E3779B1;
    localparam logic [31:0] HP2 = 32'h85EBCA77;
    localparam logic [31:0] HP3 = 32'hC2B2AE3D;
    localparam logic [31:0] HP4 = 32'h27D4EB2F;
    localparam logic [31:0] HP5 = 32'h165667B1;

    // classified request handed from front to back
    typedef struct packed {
        req_t              req;
        logic [KEY_W-1:0]  key;
        logic [LEN_W-1:0]  len;
        logic [PAY_W-1:0]  payload;
        logic [31:0]       hash;
    } job_t;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned r);
        rotl32 = (v << r) | (v >> (32 - r));
    endfunction
endpackage
`default_nettype wire

@@ rtl/lpht_if.sv @@
`default_nettype none
interface lpht_req_if;
    import lpht_pkg::*;
    logic             valid;
    logic             ready;
    logic [1:0]       req_type;
    logic [KEY_W-1:0] key_bytes;
    logic [LEN_W-1:0] key_len;
    logic [PAY_W-1:0] entry_payload;
    modport source (output valid, req_type, key_bytes, key_len, entry_payload, input ready);
    modport sink (input valid, req_type, key_bytes, key_len, entry_payload, output ready);
endinterface

interface lpht_rsp_if;
    import lpht_pkg::*;
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [PAY_W-1:0] found_payload;
    modport source (output valid, status, found_payload, input ready);
    modport sink (input valid, status, found_payload, output ready);
endinterface
`default_nettype wire

@@ rtl/linear_probe_hash_table_unit.sv @@
// channel | dir | fields
// req     | in  | req_type, key_bytes, key_len, entry_payload
// rsp     | out | status, found_payload
// front hashes a key per 4-byte word or byte, then runs its finish states F_AV1 to F_AV4;
// back probes by reading a slot (registered memory port) and checking it, then answers.
// after reset and after each clear the valid bits of all TABLE_SLOTS slots are swept,
// while no item enters the back part; the result register holds the answer until taken.
// the front hashes the next item while the back probes.
`default_nettype none
module linear_probe_hash_table_unit
    import lpht_pkg::*;
#(
    parameter int unsigned TABLE_SLOTS = 256,
    parameter int unsigned KEY_BYTES   = 8
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lpht_req_if.sink   req,
    lpht_rsp_if.source rsp
);
    job_t f_job, q_job;
    logic f_valid, f_ready, q_valid, q_ready;

    lpht_front #(.KEY_BYTES(KEY_BYTES)) u_front (
        .clk, .rst_n, .req, .job(f_job), .job_valid(f_valid), .job_ready(f_ready)
    );

    lpht_fifo u_fifo (
        .clk, .rst_n, .in_job(f_job), .in_valid(f_valid), .in_ready(f_ready),
        .out_job(q_job), .out_valid(q_valid), .out_ready(q_ready)
    );

    lpht_back #(.TABLE_SLOTS(TABLE_SLOTS)) u_back (
        .clk, .rst_n, .job(q_job), .job_valid(q_valid), .job_ready(q_ready), .rsp
    );

`ifndef SYNTH
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.status)) else $error("rsp dropped");
    a_rsp_stat: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == ST_MISS |-> rsp.found_payload == '0) else $error("miss data");
    a_hand: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && q_ready |-> !rsp.valid) else $error("overlap");
`endif
endmodule
`default_nettype wire

@@ rtl/lpht_front.sv @@
`default_nettype none
module lpht_front
    import lpht_pkg::*;
#(
    parameter int unsigned KEY_BYTES = 8
) (
    input  wire logic clk,
    input  wire logic rst_n,
    lpht_req_if.sink  req,
    output job_t      job,
    output logic      job_valid,
    input  wire logic job_ready
);
    localparam int unsigned MAXLEN = (KEY_BYTES < 8) ? KEY_BYTES : 8;

    typedef enum logic [2:0] {
        F_IDLE, F_WORD, F_BYTE, F_AV1, F_AV2, F_AV3, F_AV4, F_OUT
    } fstate_t;

    fstate_t          state_reg;
    job_t             job_reg;
    logic [31:0]      h_reg, h_next;
    logic [31:0]      t_reg, t_next;
    logic             half_reg;
    logic [LEN_W-1:0] pos_reg;
    logic [LEN_W-1:0] len_sat;
    logic [KEY_W-1:0] key_mask;
    logic [KEY_W-1:0] cur;
    logic [31:0]      w32;
    logic [7:0]       b8;

    // saturate length and mask key
    always_comb
    begin
        len_sat = (req.key_len > LEN_W'(MAXLEN)) ? LEN_W'(MAXLEN) : req.key_len;
        key_mask = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (LEN_W'(i) < len_sat)
                key_mask[8*i +: 8] = 8'hFF;
        end
    end

    assign cur = job_reg.key >> {pos_reg, 3'b000};
    assign w32 = cur[31:0];
    assign b8  = cur[7:0];

    // one multiply per cycle: half_reg selects first or second product of a round
    always_comb
    begin
        h_next = h_reg;
        t_next = t_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (req.valid) h_next = HP5 + {28'd0, len_sat};
            end
            F_WORD:
            begin
                if (!half_reg) t_next = h_reg + w32 * HP3;
                else           h_next = rotl32(t_reg, 17) * HP4;
            end
            F_BYTE:
            begin
                if (!half_reg) t_next = h_reg + {24'd0, b8} * HP5;
                else           h_next = rotl32(t_reg, 11) * HP1;
            end
            F_AV1: h_next = (h_reg ^ (h_reg >> 15)) * HP2;
            F_AV2: h_next = (h_reg ^ (h_reg >> 13)) * HP3;
            F_AV3: h_next = h_reg ^ (h_reg >> 16);
            default: ;
        endcase
    end

    assign req.ready = (state_reg == F_IDLE);
    assign job_valid = (state_reg == F_OUT);
    assign job       = job_reg;

    // hash sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            half_reg  <= 1'b0;
            pos_reg   <= '0;
        end
        else
        begin
            h_reg <= h_next;
            t_reg <= t_next;
            case (state_reg)
                F_IDLE:
                begin
                    if (req.valid)
                    begin
                        job_reg.req     <= req_t'(req.req_type);
                        job_reg.key     <= req.key_bytes & key_mask;
                        job_reg.len     <= len_sat;
                        job_reg.payload <= req.entry_payload;
                        pos_reg  <= '0;
                        half_reg <= 1'b0;
                        if (req.req_type == REQ_LOOKUP || req.req_type == REQ_INSERT)
                            state_reg <= (len_sat >= 4'd4) ? F_WORD
                                       : (len_sat != 4'd0) ? F_BYTE : F_AV1;
                        else
                        begin
                            job_reg.hash <= '0;
                            state_reg    <= F_OUT;
                        end
                    end
                end
                F_WORD, F_BYTE:
                begin
                    half_reg <= ~half_reg;
                    if (half_reg)
                    begin
                        if (state_reg == F_WORD)
                        begin
                            pos_reg <= pos_reg + 4'd4;
                            if (pos_reg + 4'd8 <= job_reg.len) state_reg <= F_WORD;
                            else if (pos_reg + 4'd4 < job_reg.len) state_reg <= F_BYTE;
                            else state_reg <= F_AV1;
                        end
                        else
                        begin
                            pos_reg <= pos_reg + 4'd1;
                            if (pos_reg + 4'd1 >= job_reg.len) state_reg <= F_AV1;
                        end
                    end
                end
                F_AV1: state_reg <= F_AV2;
                F_AV2: state_reg <= F_AV3;
                F_AV3: state_reg <= F_AV4;
                F_AV4:
                begin
                    job_reg.hash <= h_reg;
                    state_reg    <= F_OUT;
                end
                F_OUT:
                begin
                    if (job_ready) state_reg <= F_IDLE;
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid |-> !req.ready) else $error("front ready while holding job");
    a_len_sat: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid |-> job_reg.len <= LEN_W'(MAXLEN)) else $error("length not saturated");
    a_job_hold: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid && !job_ready |=> job_valid && $stable(job_reg)) else $error("job changed");
`endif
endmodule
`default_nettype wire

@@ rtl/lpht_fifo.sv @@
`default_nettype none
module lpht_fifo
    import lpht_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  job_t      in_job,
    input  wire logic in_valid,
    output logic      in_ready,
    output job_t      out_job,
    output logic      out_valid,
    input  wire logic out_ready
);
    // two-entry queue
    job_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_job   = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wp_reg] <= in_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

`ifndef SYNTH
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue overflow");
    a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> wp_reg == rp_reg) else $error("pointer slip");
    a_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop && cnt_reg == 2'd1 |=> cnt_reg == 2'd2) else $error("count slip");
`endif
endmodule
`default_nettype wire

@@ rtl/lpht_back.sv @@
`default_nettype none
module lpht_back
    import lpht_pkg::*;
#(
    parameter int unsigned TABLE_SLOTS = 256
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  job_t      job,
    input  wire logic job_valid,
    output logic      job_ready,
    lpht_rsp_if.source rsp
);
    localparam int unsigned IDX_W = $clog2(TABLE_SLOTS);
    localparam int unsigned CNT_W = IDX_W + 1;
    localparam int unsigned CLR_W = IDX_W + 1;

    typedef enum logic [2:0] {
        B_INIT, B_IDLE, B_READ, B_CHECK, B_DONE
    } bstate_t;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } slot_t;

    // slot storage; valid bits live in their own memory, swept on reset and on clear
    slot_t            slot_mem [TABLE_SLOTS];
    logic             vld_mem  [TABLE_SLOTS];
    slot_t            rd_slot_reg;
    logic             rd_vld_reg;

    bstate_t          state_reg;
    job_t             cur_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CLR_W-1:0] clr_reg;
    logic             out_valid_reg;
    logic [1:0]       out_status_reg;
    logic [PAY_W-1:0] out_pay_reg;
    logic             vld_we, slot_we;
    logic             vld_wd;
    logic [IDX_W-1:0] vld_wa;
    logic             match;

    assign match = rd_vld_reg && rd_slot_reg.len == cur_reg.len && rd_slot_reg.key == cur_reg.key;

    assign job_ready = (state_reg == B_IDLE) && !out_valid_reg;
    assign rsp.valid = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.found_payload = out_pay_reg;

    // write controls
    always_comb
    begin
        vld_we  = 1'b0;
        vld_wd  = 1'b0;
        vld_wa  = idx_reg;
        slot_we = 1'b0;
        if (state_reg == B_INIT)
        begin
            vld_we = 1'b1;
            vld_wa = clr_reg[IDX_W-1:0];
        end
        else if (state_reg == B_CHECK && cur_reg.req == REQ_INSERT && !rd_vld_reg)
        begin
            vld_we  = 1'b1;
            vld_wd  = 1'b1;
            slot_we = 1'b1;
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (vld_we)  vld_mem[vld_wa] <= vld_wd;
        if (slot_we) slot_mem[idx_reg] <= '{len: cur_reg.len, key: cur_reg.key,
                                             payload: cur_reg.payload};
        rd_vld_reg  <= vld_mem[idx_reg];
        rd_slot_reg <= slot_mem[idx_reg];
    end

    // probe sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_INIT;
            clr_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp.valid && rsp.ready) out_valid_reg <= 1'b0;
            case (state_reg)
                B_INIT:
                begin
                    if (clr_reg == CLR_W'(TABLE_SLOTS - 1))
                    begin
                        clr_reg   <= '0;
                        state_reg <= out_valid_reg ? B_DONE : B_IDLE;
                    end
                    else
                        clr_reg <= clr_reg + 1'b1;
                end
                B_IDLE:
                begin
                    if (job_valid && !out_valid_reg)
                    begin
                        cur_reg <= job;
                        idx_reg <= job.hash[IDX_W-1:0];
                        case (job.req)
                            REQ_CLEAR:
                            begin
                                count_reg      <= '0;
                                out_status_reg <= ST_OK;
                                out_pay_reg    <= '0;
                                state_reg      <= B_INIT;
                                out_valid_reg  <= 1'b1;
                            end
                            REQ_INSERT:
                            begin
                                if (count_reg >= CNT_W'(TABLE_SLOTS - 1))
                                begin
                                    out_status_reg <= ST_FULL;
                                    out_pay_reg    <= '0;
                                    out_valid_reg  <= 1'b1;
                                end
                                else
                                    state_reg <= B_READ;
                            end
                            REQ_LOOKUP: state_reg <= B_READ;
                            default:
                            begin
                                out_status_reg <= ST_OK;
                                out_pay_reg    <= '0;
                                out_valid_reg  <= 1'b1;
                            end
                        endcase
                    end
                end
                B_READ: state_reg <= B_CHECK;
                B_CHECK:
                begin
                    if (!rd_vld_reg || match)
                    begin
                        out_valid_reg <= 1'b1;
                        out_pay_reg   <= (cur_reg.req == REQ_LOOKUP && match)
                                         ? rd_slot_reg.payload : '0;
                        state_reg     <= B_IDLE;
                        if (cur_reg.req == REQ_LOOKUP)
                            out_status_reg <= match ? ST_OK : ST_MISS;
                        else if (match)
                            out_status_reg <= ST_DUP;
                        else
                        begin
                            out_status_reg <= ST_OK;
                            count_reg      <= count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= B_READ;
                    end
                end
                B_DONE: state_reg <= B_IDLE;
                default: state_reg <= B_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_SLOTS - 1)) else $error("entry count overflow");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        job_ready |-> !rsp.valid) else $error("job taken while result pending");
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != ST_OK |-> rsp.found_payload == '0) else $error("bad payload");
`endif
endmodule
`default_nettype wire
